// File: src/qpr_pkg.sv
`default_nettype none
// ============================================================================
// qpr_pkg - shared definitions for the quaternion point rotator
// Register codes, pipeline stage numbering, control struct and width helpers.
// ============================================================================
package qpr_pkg;

    localparam int QBITS              = 16;
    localparam int COORD_BITS_DEF     = 20;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // real part resets to 1.0 in Q2.14
    localparam logic signed [QBITS-1:0] QUAT_REAL_RESET = 16'sd16384;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUAT_REAL = 3'd0,
        REG_QUAT_I    = 3'd1,
        REG_QUAT_J    = 3'd2,
        REG_QUAT_K    = 3'd3,
        REG_PIVOT_X   = 3'd4,
        REG_PIVOT_Y   = 3'd5,
        REG_PIVOT_Z   = 3'd6
    } cfg_reg_t;

    // pipeline stages
    localparam int STG_OFFSET = 0;  // point minus pivot
    localparam int STG_PROD1  = 1;  // q * d partial products
    localparam int STG_T      = 2;  // t = round(q * d)
    localparam int STG_PROD2  = 3;  // t * conj(q) partial products
    localparam int STG_R      = 4;  // r = round(t * conj(q))
    localparam int STG_OUT    = 5;  // pivot restored, saturated
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;  // stage register load enables
    } pipe_ctrl_t;

    // width of a signed sum of up to four products plus rounding constant,
    // kept wide enough that the rounding shift leaves at least two bits
    function automatic int sum_w(input int prod_w, input int frac);
        int raw;
        raw = prod_w + 3;
        return (raw > frac + 1) ? raw : frac + 2;
    endfunction

    function automatic int t_w(input int coord, input int frac);
        return sum_w(coord + 1 + QBITS, frac) - frac;
    endfunction

    function automatic int r_w(input int coord, input int frac);
        return sum_w(t_w(coord, frac) + QBITS, frac) - frac;
    endfunction

endpackage
`default_nettype wire

// File: src/qpr_pipe_ctrl.sv
`default_nettype none
// ============================================================================
// qpr_pipe_ctrl - valid tracking and per-stage load enables
// A stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stalled output only holds the stages behind it that are full.
// ============================================================================
module qpr_pipe_ctrl
    import qpr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.en  = en;
    assign s_tready = en[STG_OFFSET];
    assign m_tvalid = vld_reg[STG_OUT];

endmodule
`default_nettype wire

// File: src/qpr_offset_product.sv
`default_nettype none
// ============================================================================
// qpr_offset_product - first Hamilton product t = q * (0, p - pivot)
// Three stages: offset, partial products, signed sums with rounding.
// ============================================================================
module qpr_offset_product
    import qpr_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    localparam int TW            = t_w(COORD_BITS, QUAT_FRAC_BITS)
) (
    input  wire logic                         aclk,
    input  wire pipe_ctrl_t                   ctrl,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] point_z,
    input  wire logic signed [COORD_BITS-1:0] pivot_x,
    input  wire logic signed [COORD_BITS-1:0] pivot_y,
    input  wire logic signed [COORD_BITS-1:0] pivot_z,
    input  wire logic signed [QBITS-1:0]      quat_w,
    input  wire logic signed [QBITS-1:0]      quat_i,
    input  wire logic signed [QBITS-1:0]      quat_j,
    input  wire logic signed [QBITS-1:0]      quat_k,
    output logic signed [TW-1:0]              t_w_o,
    output logic signed [TW-1:0]              t_x_o,
    output logic signed [TW-1:0]              t_y_o,
    output logic signed [TW-1:0]              t_z_o
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + QBITS;
    localparam int SW = sum_w(PW, QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;
    logic signed [PW-1:0] prod_reg  [12];
    logic signed [PW-1:0] prod_next [12];
    logic signed [TW-1:0] t_reg     [4];
    logic signed [TW-1:0] t_next    [4];
    logic signed [SW-1:0] sum_v     [4];
    logic signed [SW-1:0] sh_v      [4];

    always_comb begin
        dx_next = DW'(point_x) - DW'(pivot_x);
        dy_next = DW'(point_y) - DW'(pivot_y);
        dz_next = DW'(point_z) - DW'(pivot_z);
    end

    always_comb begin
        prod_next[0]  = PW'(quat_i) * PW'(dx_reg);
        prod_next[1]  = PW'(quat_j) * PW'(dy_reg);
        prod_next[2]  = PW'(quat_k) * PW'(dz_reg);
        prod_next[3]  = PW'(quat_w) * PW'(dx_reg);
        prod_next[4]  = PW'(quat_j) * PW'(dz_reg);
        prod_next[5]  = PW'(quat_k) * PW'(dy_reg);
        prod_next[6]  = PW'(quat_w) * PW'(dy_reg);
        prod_next[7]  = PW'(quat_i) * PW'(dz_reg);
        prod_next[8]  = PW'(quat_k) * PW'(dx_reg);
        prod_next[9]  = PW'(quat_w) * PW'(dz_reg);
        prod_next[10] = PW'(quat_i) * PW'(dy_reg);
        prod_next[11] = PW'(quat_j) * PW'(dx_reg);
    end

    // round half up: add half an lsb, then floor shift
    always_comb begin
        sum_v[0] = -SW'(prod_reg[0]) - SW'(prod_reg[1]) - SW'(prod_reg[2]) + RND;
        sum_v[1] =  SW'(prod_reg[3]) + SW'(prod_reg[4]) - SW'(prod_reg[5]) + RND;
        sum_v[2] =  SW'(prod_reg[6]) - SW'(prod_reg[7]) + SW'(prod_reg[8]) + RND;
        sum_v[3] =  SW'(prod_reg[9]) + SW'(prod_reg[10]) - SW'(prod_reg[11]) + RND;
        for (int n = 0; n < 4; n++) begin
            sh_v[n]   = sum_v[n] >>> QUAT_FRAC_BITS;
            t_next[n] = sh_v[n][TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[STG_OFFSET]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
        if (ctrl.en[STG_PROD1]) begin
            prod_reg <= prod_next;
        end
        if (ctrl.en[STG_T]) begin
            t_reg <= t_next;
        end
    end

    assign t_w_o = t_reg[0];
    assign t_x_o = t_reg[1];
    assign t_y_o = t_reg[2];
    assign t_z_o = t_reg[3];

endmodule
`default_nettype wire

// File: src/qpr_conj_product.sv
`default_nettype none
// ============================================================================
// qpr_conj_product - vector part of the second product r = t * conj(q)
// Two stages: partial products, then signed sums with rounding.
// ============================================================================
module qpr_conj_product
    import qpr_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    localparam int TW            = t_w(COORD_BITS, QUAT_FRAC_BITS),
    localparam int RW            = r_w(COORD_BITS, QUAT_FRAC_BITS)
) (
    input  wire logic                    aclk,
    input  wire pipe_ctrl_t              ctrl,
    input  wire logic signed [TW-1:0]    t_w_i,
    input  wire logic signed [TW-1:0]    t_x_i,
    input  wire logic signed [TW-1:0]    t_y_i,
    input  wire logic signed [TW-1:0]    t_z_i,
    input  wire logic signed [QBITS-1:0] quat_w,
    input  wire logic signed [QBITS-1:0] quat_i,
    input  wire logic signed [QBITS-1:0] quat_j,
    input  wire logic signed [QBITS-1:0] quat_k,
    output logic signed [RW-1:0]         r_x_o,
    output logic signed [RW-1:0]         r_y_o,
    output logic signed [RW-1:0]         r_z_o
);

    localparam int PW = TW + QBITS;
    localparam int SW = sum_w(PW, QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [PW-1:0] prod_reg  [12];
    logic signed [PW-1:0] prod_next [12];
    logic signed [RW-1:0] r_reg     [3];
    logic signed [RW-1:0] r_next    [3];
    logic signed [SW-1:0] sum_v     [3];
    logic signed [SW-1:0] sh_v      [3];

    always_comb begin
        prod_next[0]  = PW'(t_w_i) * PW'(quat_i);
        prod_next[1]  = PW'(t_x_i) * PW'(quat_w);
        prod_next[2]  = PW'(t_y_i) * PW'(quat_k);
        prod_next[3]  = PW'(t_z_i) * PW'(quat_j);
        prod_next[4]  = PW'(t_w_i) * PW'(quat_j);
        prod_next[5]  = PW'(t_x_i) * PW'(quat_k);
        prod_next[6]  = PW'(t_y_i) * PW'(quat_w);
        prod_next[7]  = PW'(t_z_i) * PW'(quat_i);
        prod_next[8]  = PW'(t_w_i) * PW'(quat_k);
        prod_next[9]  = PW'(t_x_i) * PW'(quat_j);
        prod_next[10] = PW'(t_y_i) * PW'(quat_i);
        prod_next[11] = PW'(t_z_i) * PW'(quat_w);
    end

    always_comb begin
        sum_v[0] = -SW'(prod_reg[0]) + SW'(prod_reg[1]) - SW'(prod_reg[2])
                   + SW'(prod_reg[3]) + RND;
        sum_v[1] = -SW'(prod_reg[4]) + SW'(prod_reg[5]) + SW'(prod_reg[6])
                   - SW'(prod_reg[7]) + RND;
        sum_v[2] = -SW'(prod_reg[8]) - SW'(prod_reg[9]) + SW'(prod_reg[10])
                   + SW'(prod_reg[11]) + RND;
        for (int n = 0; n < 3; n++) begin
            sh_v[n]   = sum_v[n] >>> QUAT_FRAC_BITS;
            r_next[n] = sh_v[n][RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[STG_PROD2]) begin
            prod_reg <= prod_next;
        end
        if (ctrl.en[STG_R]) begin
            r_reg <= r_next;
        end
    end

    assign r_x_o = r_reg[0];
    assign r_y_o = r_reg[1];
    assign r_z_o = r_reg[2];

endmodule
`default_nettype wire

// File: src/qpr_restore.sv
`default_nettype none
// ============================================================================
// qpr_restore - add the pivot back and clip to the coordinate range
// Output stage; its registers also serve as the output holding register.
// ============================================================================
module qpr_restore
    import qpr_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    localparam int RW            = r_w(COORD_BITS, QUAT_FRAC_BITS)
) (
    input  wire logic                         aclk,
    input  wire pipe_ctrl_t                   ctrl,
    input  wire logic signed [RW-1:0]         r_x_i,
    input  wire logic signed [RW-1:0]         r_y_i,
    input  wire logic signed [RW-1:0]         r_z_i,
    input  wire logic signed [COORD_BITS-1:0] pivot_x,
    input  wire logic signed [COORD_BITS-1:0] pivot_y,
    input  wire logic signed [COORD_BITS-1:0] pivot_z,
    output logic signed [COORD_BITS-1:0]      rotated_x,
    output logic signed [COORD_BITS-1:0]      rotated_y,
    output logic signed [COORD_BITS-1:0]      rotated_z,
    output logic                              saturated
);

    localparam int AW = ((RW > COORD_BITS) ? RW : COORD_BITS) + 1;
    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [AW-1:0]         sum_v  [3];
    logic [2:0]                   over;
    logic signed [COORD_BITS-1:0] rot_next [3];
    logic signed [COORD_BITS-1:0] rot_reg  [3];
    logic                         sat_next;
    logic                         sat_reg;

    always_comb begin
        sum_v[0] = AW'(r_x_i) + AW'(pivot_x);
        sum_v[1] = AW'(r_y_i) + AW'(pivot_y);
        sum_v[2] = AW'(r_z_i) + AW'(pivot_z);
        for (int n = 0; n < 3; n++) begin
            // in range when all bits from the coordinate sign up agree
            over[n] = !((&sum_v[n][AW-1:COORD_BITS-1]) || !(|sum_v[n][AW-1:COORD_BITS-1]));
            if (over[n]) begin
                rot_next[n] = sum_v[n][AW-1] ? MINV : MAXV;
            end else begin
                rot_next[n] = sum_v[n][COORD_BITS-1:0];
            end
        end
        sat_next = |over;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[STG_OUT]) begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign rotated_x = rot_reg[0];
    assign rotated_y = rot_reg[1];
    assign rotated_z = rot_reg[2];
    assign saturated = sat_reg;

endmodule
`default_nettype wire

// File: src/quaternion_point_rotate.sv
`default_nettype none
// A point passes the OFFSET, PROD1, T, PROD2, R and OUT stage registers to m_tvalid.
// Throughput: one point per cycle unless stalled; the six-stage pipeline is overlapped.
// Backpressure stalls only the full stages behind the output register.
// Reset: synchronous, active low; clears stage valid bits and loads the
// configuration registers with q = (1.0, 0, 0, 0) and a zero pivot.
// ============================================================================
// quaternion_point_rotate - rotate point stream about a pivot by q * p * conj(q)
// Configuration registers, pipeline control and the three datapath sections.
// ============================================================================
module quaternion_point_rotate
    import qpr_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    localparam int CFG_W         = (COORD_BITS > QBITS) ? COORD_BITS : QBITS,
    localparam int DATA_W        = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // point input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // point_x, point_y, point_z
    // rotated output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata,   // rotated_x, rotated_y, rotated_z
    output logic                       m_tuser    // saturated
);

    localparam int C  = COORD_BITS;
    localparam int TW = t_w(COORD_BITS, QUAT_FRAC_BITS);
    localparam int RW = r_w(COORD_BITS, QUAT_FRAC_BITS);

    logic signed [QBITS-1:0] quat_w_reg, quat_i_reg, quat_j_reg, quat_k_reg;
    logic signed [QBITS-1:0] quat_w_next, quat_i_next, quat_j_next, quat_k_next;
    logic signed [C-1:0]     pivot_x_reg, pivot_y_reg, pivot_z_reg;
    logic signed [C-1:0]     pivot_x_next, pivot_y_next, pivot_z_next;

    always_comb begin
        quat_w_next  = quat_w_reg;
        quat_i_next  = quat_i_reg;
        quat_j_next  = quat_j_reg;
        quat_k_next  = quat_k_reg;
        pivot_x_next = pivot_x_reg;
        pivot_y_next = pivot_y_reg;
        pivot_z_next = pivot_z_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_QUAT_REAL: quat_w_next  = cfg_wdata[QBITS-1:0];
                REG_QUAT_I:    quat_i_next  = cfg_wdata[QBITS-1:0];
                REG_QUAT_J:    quat_j_next  = cfg_wdata[QBITS-1:0];
                REG_QUAT_K:    quat_k_next  = cfg_wdata[QBITS-1:0];
                REG_PIVOT_X:   pivot_x_next = cfg_wdata[C-1:0];
                REG_PIVOT_Y:   pivot_y_next = cfg_wdata[C-1:0];
                REG_PIVOT_Z:   pivot_z_next = cfg_wdata[C-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg  <= QUAT_REAL_RESET;
            quat_i_reg  <= '0;
            quat_j_reg  <= '0;
            quat_k_reg  <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
        end else begin
            quat_w_reg  <= quat_w_next;
            quat_i_reg  <= quat_i_next;
            quat_j_reg  <= quat_j_next;
            quat_k_reg  <= quat_k_next;
            pivot_x_reg <= pivot_x_next;
            pivot_y_reg <= pivot_y_next;
            pivot_z_reg <= pivot_z_next;
        end
    end

    pipe_ctrl_t          ctrl;
    logic signed [TW-1:0] t_w_s, t_x_s, t_y_s, t_z_s;
    logic signed [RW-1:0] r_x_s, r_y_s, r_z_s;
    logic signed [C-1:0]  rot_x, rot_y, rot_z;
    logic                 sat;

    qpr_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    qpr_offset_product #(
        .COORD_BITS     (COORD_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_offset (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .point_x (s_tdata[C-1:0]),
        .point_y (s_tdata[2*C-1:C]),
        .point_z (s_tdata[3*C-1:2*C]),
        .pivot_x (pivot_x_reg),
        .pivot_y (pivot_y_reg),
        .pivot_z (pivot_z_reg),
        .quat_w  (quat_w_reg),
        .quat_i  (quat_i_reg),
        .quat_j  (quat_j_reg),
        .quat_k  (quat_k_reg),
        .t_w_o   (t_w_s),
        .t_x_o   (t_x_s),
        .t_y_o   (t_y_s),
        .t_z_o   (t_z_s)
    );

    qpr_conj_product #(
        .COORD_BITS     (COORD_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_conj (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .t_w_i  (t_w_s),
        .t_x_i  (t_x_s),
        .t_y_i  (t_y_s),
        .t_z_i  (t_z_s),
        .quat_w (quat_w_reg),
        .quat_i (quat_i_reg),
        .quat_j (quat_j_reg),
        .quat_k (quat_k_reg),
        .r_x_o  (r_x_s),
        .r_y_o  (r_y_s),
        .r_z_o  (r_z_s)
    );

    qpr_restore #(
        .COORD_BITS     (COORD_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_restore (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .r_x_i     (r_x_s),
        .r_y_i     (r_y_s),
        .r_z_i     (r_z_s),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .pivot_z   (pivot_z_reg),
        .rotated_x (rot_x),
        .rotated_y (rot_y),
        .rotated_z (rot_z),
        .saturated (sat)
    );

    always_comb begin
        m_tdata            = '0;
        m_tdata[3*C-1:0]   = {rot_z, rot_y, rot_x};
    end

    assign m_tuser = sat;

endmodule
`default_nettype wire

// File: src/qpr_checker.sv
`default_nettype none
// ============================================================================
// qpr_checker - port-level checks for quaternion_point_rotate
// Output hold under stall, reset, ready propagation and pipeline latency.
// ============================================================================
module qpr_checker #(
    parameter int DATA_W = 64
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic              m_tuser
);

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // nothing comes out of a freshly reset pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set right after reset");

    // a ready sink never backs up the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while sink is ready");

    // six-stage latency with an open sink
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready
            ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind quaternion_point_rotate qpr_checker #(.DATA_W(DATA_W)) u_qpr_checker (.*);
`default_nettype wire
